// ===== sv/multi_key_top_k_selector_top_macros.svh =====
// Assertion macros shared by the checker of the top-k selector
`ifndef MULTI_KEY_TOP_K_SELECTOR_TOP_MACROS_SVH
`define MULTI_KEY_TOP_K_SELECTOR_TOP_MACROS_SVH

// same-cycle implication under reset
`define MKTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("top-k selector check failed");

// next-cycle implication under reset
`define MKTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("top-k selector check failed");

`endif

// ===== sv/mkts_pkg.sv =====
// Types and constants of the top-k selector
package mkts_pkg;

	localparam int MAX_K      = 32;
	localparam int KEY_BITS   = 32;
	localparam int TAG_BITS   = 32;
	localparam int TOPC_W     = 6;
	localparam int KCNT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int FILL_W     = $clog2(MAX_K + 1);
	localparam int CMP_W      = (FILL_W > TOPC_W) ? FILL_W : TOPC_W;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 2'd2;

	localparam logic [TOPC_W-1:0] TOP_COUNT_RST = 6'd32;
	localparam logic [KCNT_W-1:0] KEY_COUNT_RST = 2'd1;

	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic signed [KEY_BITS-1:0] key_first;
		logic signed [KEY_BITS-1:0] key_second;
		logic [TAG_BITS-1:0]        tag;
	} row_t;

	typedef struct packed {
		logic              descending;
		logic [KCNT_W-1:0] key_count;
	} cmp_cfg_t;

	typedef struct packed {
		row_t row;
		logic last;
		logic empty;
	} res_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_NEW,
		CELL_PREV,
		CELL_NEXT
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} ctrl_state_t;

endpackage

// ===== sv/mkts_row_if.sv =====
// Input row channel of the top-k selector
interface mkts_row_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [mkts_pkg::KEY_BITS-1:0] key_first;
	logic signed [mkts_pkg::KEY_BITS-1:0] key_second;
	logic [mkts_pkg::TAG_BITS-1:0]        row_tag;

	modport source (output valid, output op, output key_first, output key_second,
		output row_tag, input ready);
	modport sink (input valid, input op, input key_first, input key_second,
		input row_tag, output ready);
endinterface

// ===== sv/mkts_res_if.sv =====
// Result channel of the top-k selector
interface mkts_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [mkts_pkg::KEY_BITS-1:0] out_key_first;
	logic signed [mkts_pkg::KEY_BITS-1:0] out_key_second;
	logic [mkts_pkg::TAG_BITS-1:0]        out_tag;
	logic                                last;
	logic                                empty_result;

	modport source (output valid, output out_key_first, output out_key_second,
		output out_tag, output last, output empty_result, input ready);
	modport sink (input valid, input out_key_first, input out_key_second,
		input out_tag, input last, input empty_result, output ready);
endinterface

// ===== sv/mkts_cfg_if.sv =====
// Configuration write channel of the top-k selector
interface mkts_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mkts_pkg::CFG_IDX_W-1:0]     idx;
	logic [mkts_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== sv/mkts_cell.sv =====
// One slot of the insertion chain: holds a row and compares the incoming row against it
module mkts_cell (
	input  logic                clk,
	input  mkts_pkg::cell_cmd_t cmd,
	input  mkts_pkg::cmp_cfg_t  cmp_cfg,
	input  mkts_pkg::row_t      new_row,
	input  mkts_pkg::row_t      prev_row,
	input  mkts_pkg::row_t      next_row,
	output mkts_pkg::row_t      row,
	output logic                beats
);

	mkts_pkg::row_t row_q;
	logic use_first, use_second;
	logic lt_first, eq_first, lt_second;

	always_comb begin
		use_first  = (cmp_cfg.key_count != 2'd0);
		use_second = (cmp_cfg.key_count inside {2'd2, 2'd3});
		eq_first   = (new_row.key_first == row_q.key_first);
		if (cmp_cfg.descending) begin
			lt_first  = ($signed(new_row.key_first) > $signed(row_q.key_first));
			lt_second = ($signed(new_row.key_second) > $signed(row_q.key_second));
		end else begin
			lt_first  = ($signed(new_row.key_first) < $signed(row_q.key_first));
			lt_second = ($signed(new_row.key_second) < $signed(row_q.key_second));
		end
		beats = use_first & (lt_first | (eq_first & use_second & lt_second));
	end

	always_ff @(posedge clk) begin
		case (cmd)
			mkts_pkg::CELL_NEW:  row_q <= new_row;
			mkts_pkg::CELL_PREV: row_q <= prev_row;
			mkts_pkg::CELL_NEXT: row_q <= next_row;
			default:             row_q <= row_q;
		endcase
	end

	assign row = row_q;

endmodule

// ===== sv/mkts_ctrl.sv =====
// Chain control: fill count, insertion point, drain sequencing and result register
module mkts_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_op,
	output logic                            in_ready,
	input  logic [mkts_pkg::TOPC_W-1:0]     top_count,
	input  logic [mkts_pkg::MAX_K-1:0]      beats,
	input  mkts_pkg::row_t                  head_row,
	output mkts_pkg::cell_cmd_t             cmd [mkts_pkg::MAX_K],
	output logic                            out_valid,
	input  logic                            out_ready,
	output mkts_pkg::res_t                  res
);

	localparam int FW = mkts_pkg::FILL_W;
	localparam int NK = mkts_pkg::MAX_K;

	mkts_pkg::ctrl_state_t state_q, state_d;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rem_q;
	logic          out_valid_q;
	mkts_pkg::res_t res_q;

	logic [FW-1:0] limit;
	logic [FW-1:0] drain_n;
	logic [FW:0]   fill_inc;
	logic [FW-1:0] fill_new;
	logic [NK-1:0] hit, ge_pos, eq_pos, lt_lim;
	logic          ins_ok, accept, offer_go, flush_go, emit, shift, done;

	always_comb begin
		logic [mkts_pkg::CMP_W-1:0] tc_ext, mk_ext;
		tc_ext   = mkts_pkg::CMP_W'(top_count);
		mk_ext   = mkts_pkg::CMP_W'(NK);
		limit    = FW'((tc_ext > mk_ext) ? mk_ext : tc_ext);
		drain_n  = (fill_q < limit) ? fill_q : limit;
		fill_inc = {1'b0, fill_q} + 1'b1;
		fill_new = (fill_inc > {1'b0, limit}) ? limit : fill_inc[FW-1:0];
	end

	for (genvar g = 0; g < NK; g++) begin : g_pos
		assign hit[g]    = beats[g] & (FW'(g) < fill_q);
		assign ge_pos[g] = (|hit[g:0]) | (FW'(g) >= fill_q);
		assign lt_lim[g] = (FW'(g) < limit);
		if (g == 0) begin : g_first
			assign eq_pos[g] = ge_pos[g];
		end else begin : g_rest
			assign eq_pos[g] = ge_pos[g] & ~ge_pos[g-1];
		end
	end

	assign ins_ok = |(eq_pos & lt_lim);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mkts_pkg::ST_IDLE:  if (flush_go) state_d = mkts_pkg::ST_DRAIN;
			mkts_pkg::ST_DRAIN: if (done) state_d = mkts_pkg::ST_IDLE;
			default:            state_d = mkts_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == mkts_pkg::ST_IDLE);
		accept   = in_valid & in_ready;
		offer_go = accept & (in_op == mkts_pkg::OP_OFFER) & ins_ok;
		flush_go = accept & (in_op == mkts_pkg::OP_FLUSH);
		emit     = (state_q == mkts_pkg::ST_DRAIN) & (~out_valid_q | out_ready);
		shift    = emit & (rem_q > FW'(1));
		done     = emit & ~shift;
	end

	for (genvar g = 0; g < NK; g++) begin : g_cmd
		always_comb begin
			if (offer_go) begin
				if (eq_pos[g]) cmd[g] = mkts_pkg::CELL_NEW;
				else if (ge_pos[g]) cmd[g] = mkts_pkg::CELL_PREV;
				else cmd[g] = mkts_pkg::CELL_HOLD;
			end else if (shift) begin
				cmd[g] = mkts_pkg::CELL_NEXT;
			end else begin
				cmd[g] = mkts_pkg::CELL_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mkts_pkg::ST_IDLE;
			fill_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (flush_go) begin
				fill_q <= '0;
				rem_q  <= drain_n;
			end else if (offer_go) begin
				fill_q <= fill_new;
			end
			if (shift) rem_q <= rem_q - 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (rem_q == '0) begin
				res_q.row   <= '0;
				res_q.empty <= 1'b1;
			end else begin
				res_q.row   <= head_row;
				res_q.empty <= 1'b0;
			end
			res_q.last <= ~shift;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/multi_key_top_k_selector_top.sv =====
// Top level of the streaming top-k selector with lexicographic signed keys
//
//  channel   dir  handshake       payload
//  rows      in   valid / ready   op, key_first, key_second, row_tag
//  results   out  valid / ready   out_key_first, out_key_second, out_tag, last, empty_result
//  cfg       in   valid / ready   idx, data (always ready)
//
// An offered row is taken while idle: every slot of the chain compares in parallel and the
// chain shifts behind the insertion point. A flush drains the kept rows, up to the limit,
// through slot 0 into the result register (one empty result if none); rows wait meanwhile.
// Reset clears the fill count and control only; slot contents need no clearing.
module multi_key_top_k_selector_top (
	input  logic              clk,
	input  logic              arst_n,
	mkts_row_if.sink          rows,
	mkts_res_if.source        results,
	mkts_cfg_if.sink          cfg
);

	localparam int NK = mkts_pkg::MAX_K;

	logic [mkts_pkg::TOPC_W-1:0] top_count_q;
	logic                        descending_q;
	logic [mkts_pkg::KCNT_W-1:0] key_count_q;

	mkts_pkg::cmp_cfg_t  cmp_cfg;
	mkts_pkg::row_t      new_row;
	mkts_pkg::row_t      cell_row [NK];
	mkts_pkg::cell_cmd_t cmd [NK];
	logic [NK-1:0]       beats;
	mkts_pkg::res_t      res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q  <= mkts_pkg::TOP_COUNT_RST;
			descending_q <= 1'b0;
			key_count_q  <= mkts_pkg::KEY_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.idx)
				mkts_pkg::CFG_TOP_COUNT:  top_count_q  <= cfg.data[mkts_pkg::TOPC_W-1:0];
				mkts_pkg::CFG_DESCENDING: descending_q <= cfg.data[0];
				mkts_pkg::CFG_KEY_COUNT:  key_count_q  <= cfg.data[mkts_pkg::KCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cmp_cfg.descending = descending_q;
	assign cmp_cfg.key_count  = key_count_q;

	assign new_row.key_first  = rows.key_first;
	assign new_row.key_second = rows.key_second;
	assign new_row.tag        = rows.row_tag;

	for (genvar g = 0; g < NK; g++) begin : g_cell
		mkts_pkg::row_t prev_row, next_row;
		if (g == 0) begin : g_head
			assign prev_row = new_row;
		end else begin : g_body
			assign prev_row = cell_row[g-1];
		end
		if (g == NK - 1) begin : g_tail
			assign next_row = cell_row[g];
		end else begin : g_inner
			assign next_row = cell_row[g+1];
		end

		mkts_cell u_cell (
			.clk      (clk),
			.cmd      (cmd[g]),
			.cmp_cfg  (cmp_cfg),
			.new_row  (new_row),
			.prev_row (prev_row),
			.next_row (next_row),
			.row      (cell_row[g]),
			.beats    (beats[g])
		);
	end

	mkts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rows.valid),
		.in_op     (rows.op),
		.in_ready  (rows.ready),
		.top_count (top_count_q),
		.beats     (beats),
		.head_row  (cell_row[0]),
		.cmd       (cmd),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.res       (res)
	);

	assign results.out_key_first  = res.row.key_first;
	assign results.out_key_second = res.row.key_second;
	assign results.out_tag        = res.row.tag;
	assign results.last           = res.last;
	assign results.empty_result   = res.empty;

endmodule

// ===== sv/mkts_checker.sv =====
// Port-level checker of the top-k selector and its bind to the top level
`include "multi_key_top_k_selector_top_macros.svh"

module mkts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rows_valid,
	input logic                              rows_ready,
	input logic                              rows_op,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [mkts_pkg::KEY_BITS-1:0] res_key_first,
	input logic signed [mkts_pkg::KEY_BITS-1:0] res_key_second,
	input logic [mkts_pkg::TAG_BITS-1:0]     res_tag,
	input logic                              res_last,
	input logic                              res_empty
);

	logic flush_txn, res_stall, empty_out, fields_zero;

	assign flush_txn   = rows_valid & rows_ready & (rows_op == mkts_pkg::OP_FLUSH);
	assign res_stall   = res_valid & ~res_ready;
	assign empty_out   = res_valid & res_empty;
	assign fields_zero = (res_key_first == '0) && (res_key_second == '0) && (res_tag == '0);

	`MKTS_ASSERT_NOW(a_empty_is_last, clk, arst_n, empty_out, res_last)
	`MKTS_ASSERT_NOW(a_empty_zero, clk, arst_n, empty_out, fields_zero)
	`MKTS_ASSERT_NEXT(a_flush_blocks_rows, clk, arst_n, flush_txn, !rows_ready)
	`MKTS_ASSERT_NEXT(a_stall_holds, clk, arst_n, res_stall, res_valid && $stable(res_tag) && $stable(res_key_first) && $stable(res_last))

endmodule

bind multi_key_top_k_selector_top mkts_checker u_mkts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rows_valid     (rows.valid),
	.rows_ready     (rows.ready),
	.rows_op        (rows.op),
	.res_valid      (results.valid),
	.res_ready      (results.ready),
	.res_key_first  (results.out_key_first),
	.res_key_second (results.out_key_second),
	.res_tag        (results.out_tag),
	.res_last       (results.last),
	.res_empty      (results.empty_result)
);

// ===== tb/sv/multi_key_top_k_selector_checker.sv =====
// Checker for the top-k selector: tracks the kept rows and compares every emitted row
`timescale 1ns / 1ps

module multi_key_top_k_selector_checker
	import mkts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mkts_row_if  rows,
	mkts_res_if  results,
	mkts_cfg_if  cfg,
	output int   errors,
	output int   pending,
	output int   results_seen
);

	row_t              best_rows [MAX_K];
	int                best_count;
	logic [TOPC_W-1:0] limit_reg;
	logic              desc_reg;
	logic [KCNT_W-1:0] keys_reg;
	res_t              flush_rows_due [$];
	int                fail_count;

	assign errors = fail_count;

	task automatic report_mismatch(input string what, input logic [KEY_BITS-1:0] seen,
		input logic [KEY_BITS-1:0] due);
		$display("%0t ns  %s: got %h, want %h", $time, what, seen, due);
		fail_count++;
	endtask

	function automatic int row_limit();
		return (limit_reg > MAX_K) ? MAX_K : int'(limit_reg);
	endfunction

	function automatic int key_order(input logic signed [KEY_BITS-1:0] a,
		input logic signed [KEY_BITS-1:0] b);
		return (a < b) ? -1 : ((a > b) ? 1 : 0);
	endfunction

	// true when the new row strictly outranks a kept one
	function automatic bit outranks(input row_t fresh, input row_t held);
		int n;
		int c;
		n = (keys_reg > 2) ? 2 : int'(keys_reg);
		c = 0;
		if (n >= 1) c = key_order(fresh.key_first, held.key_first);
		if (c == 0 && n >= 2) c = key_order(fresh.key_second, held.key_second);
		if (desc_reg) c = -c;
		return c < 0;
	endfunction

	task automatic keep_row(input row_t fresh);
		int lim;
		int pos;
		int nfill;
		int i;
		lim = row_limit();
		pos = 0;
		while (pos < best_count && !outranks(fresh, best_rows[pos])) pos++;
		if (pos >= lim) return;
		nfill = (best_count + 1 > lim) ? lim : best_count + 1;
		for (i = nfill - 1; i > pos; i--) best_rows[i] = best_rows[i - 1];
		best_rows[pos] = fresh;
		best_count = nfill;
	endtask

	task automatic emit_best_rows();
		int lim;
		int n;
		int i;
		res_t due;
		lim = row_limit();
		n = (best_count < lim) ? best_count : lim;
		best_count = 0;
		if (n == 0) begin
			due = '0;
			due.last = 1'b1;
			due.empty = 1'b1;
			flush_rows_due = {flush_rows_due, due};
		end
		for (i = 0; i < n; i++) begin
			due.row = best_rows[i];
			due.last = (i == n - 1);
			due.empty = 1'b0;
			flush_rows_due = {flush_rows_due, due};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t due;
		row_t fresh;
		if (!arst_n) begin
			best_count = 0;
			limit_reg = TOP_COUNT_RST;
			desc_reg = 1'b0;
			keys_reg = KEY_COUNT_RST;
			flush_rows_due.delete();
			fail_count = 0;
			results_seen <= 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					CFG_TOP_COUNT: limit_reg = cfg.data[TOPC_W-1:0];
					CFG_DESCENDING: desc_reg = cfg.data[0];
					CFG_KEY_COUNT: keys_reg = cfg.data[KCNT_W-1:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				results_seen <= results_seen + 1;
				if (flush_rows_due.size() == 0) begin
					report_mismatch("result with nothing due", results.out_tag, '0);
				end else begin
					due = flush_rows_due.pop_front();
					if (results.out_key_first !== due.row.key_first)
						report_mismatch("out_key_first", results.out_key_first,
							due.row.key_first);
					if (results.out_key_second !== due.row.key_second)
						report_mismatch("out_key_second", results.out_key_second,
							due.row.key_second);
					if (results.out_tag !== due.row.tag)
						report_mismatch("out_tag", results.out_tag, due.row.tag);
					if (results.last !== due.last)
						report_mismatch("last", 32'(results.last), 32'(due.last));
					if (results.empty_result !== due.empty)
						report_mismatch("empty_result", 32'(results.empty_result),
							32'(due.empty));
				end
			end
			if (rows.valid && rows.ready) begin
				if (rows.op == OP_FLUSH) begin
					emit_best_rows();
				end else begin
					fresh.key_first = rows.key_first;
					fresh.key_second = rows.key_second;
					fresh.tag = rows.row_tag;
					keep_row(fresh);
				end
			end
			pending <= flush_rows_due.size();
		end
	end

endmodule

// ===== tb/sv/multi_key_top_k_selector_top_test.sv =====
// Testbench top for the top-k selector: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module multi_key_top_k_selector_top_test;
	import mkts_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int ITEM_TARGET   = 160;
	localparam int BIG_PHASE     = 2;
	localparam int HOLD_PHASE    = 5;
	localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
	localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};

	typedef enum {SINK_OPEN, SINK_COIN, SINK_EVERY4, SINK_SPARSE} sink_style_t;
	typedef enum {KEYS_NARROW, KEYS_EDGE, KEYS_WIDE} key_spread_t;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   results_seen;
	int   cycles;
	int   items_sent;
	int   flushes_sent;
	int   burst_left;
	bit   gaps_on;
	bit   hold_req;

	mkts_row_if row_ch ();
	mkts_res_if res_ch ();
	mkts_cfg_if cfg_ch ();

	multi_key_top_k_selector_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rows    (row_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	multi_key_top_k_selector_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.rows         (row_ch),
		.results      (res_ch),
		.cfg          (cfg_ch),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: switches among random stall styles, long hold on request
	initial begin
		int          hold_left;
		int          tick;
		bit          hold_seen;
		sink_style_t style;
		res_ch.ready <= 1'b0;
		hold_left = 0;
		tick = 0;
		hold_seen = 1'b0;
		style = SINK_OPEN;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (tick % 50 == 0) style = sink_style_t'($urandom_range(0, 3));
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (style)
					SINK_OPEN: res_ch.ready <= 1'b1;
					SINK_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
					SINK_EVERY4: res_ch.ready <= (tick % 4 != 0);
					default: res_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic signed [KEY_BITS-1:0] pick_key(input key_spread_t spread);
		int v;
		case (spread)
			KEYS_NARROW: begin
				v = $urandom_range(0, 6);
				return v - 3;
			end
			KEYS_EDGE: begin
				case ($urandom_range(0, 4))
					0: return KEY_MIN;
					1: return KEY_MAX;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [TOPC_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return TOPC_W'(1);
			2: return TOPC_W'(MAX_K);
			3: return '1;
			4: return TOPC_W'(MAX_K + 1);
			default: return TOPC_W'($urandom_range(2, 12));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [TOPC_W-1:0] top_count, input logic descending,
		input logic [KCNT_W-1:0] key_count);
		write_reg(CFG_TOP_COUNT, CFG_DATA_W'(top_count));
		write_reg(CFG_DESCENDING, CFG_DATA_W'(descending));
		write_reg(CFG_KEY_COUNT, CFG_DATA_W'(key_count));
	endtask

	task automatic send_item(input logic op, input logic signed [KEY_BITS-1:0] kf,
		input logic signed [KEY_BITS-1:0] ks, input logic [TAG_BITS-1:0] tag);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				row_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		row_ch.valid <= 1'b1;
		row_ch.op <= op;
		row_ch.key_first <= kf;
		row_ch.key_second <= ks;
		row_ch.row_tag <= tag;
		@(posedge clk);
		while (!row_ch.ready) @(posedge clk);
		items_sent++;
		if (op == OP_FLUSH) flushes_sent++;
	endtask

	task automatic offer(input logic signed [KEY_BITS-1:0] kf,
		input logic signed [KEY_BITS-1:0] ks);
		send_item(OP_OFFER, kf, ks, $urandom);
	endtask

	task automatic flush();
		send_item(OP_FLUSH, $urandom, $urandom, $urandom);
	endtask

	// hold the sender until every due result is out and the block has gone quiet
	task automatic wait_drained();
		row_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          phase;
		int          n;
		key_spread_t spread;
		arst_n <= 1'b0;
		cycles <= 0;
		row_ch.valid <= 1'b0;
		row_ch.op <= OP_OFFER;
		row_ch.key_first <= '0;
		row_ch.key_second <= '0;
		row_ch.row_tag <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.idx <= CFG_TOP_COUNT;
		cfg_ch.data <= '0;
		hold_req = 1'b0;
		items_sent = 0;
		flushes_sent = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty flush, extreme keys, tie on the first key
		flush();
		send_item(OP_OFFER, KEY_MAX, 0, '1);
		send_item(OP_OFFER, KEY_MIN, 5, '0);
		offer(0, -1);
		offer(-1, KEY_MAX);
		offer(0, KEY_MIN);
		flush();
		wait_drained();

		// two keys, largest first, limit three
		set_limits(TOPC_W'(3), 1'b1, KCNT_W'(2));
		offer(7, 1);
		offer(7, KEY_MAX);
		offer(7, KEY_MIN);
		offer(KEY_MIN, 0);
		offer(KEY_MAX, -1);
		flush();
		wait_drained();

		// zero limit with an out-of-range key count
		set_limits('0, 1'b0, KCNT_W'(3));
		offer(1, 1);
		flush();
		wait_drained();

		// oversized limit, no keys: arrival order, then limit lowered under kept rows
		set_limits('1, 1'b0, '0);
		offer(9, 9);
		offer(-9, -9);
		offer(3, 3);
		wait_drained();
		write_reg(CFG_TOP_COUNT, CFG_DATA_W'(2));
		offer(KEY_MIN, KEY_MIN);
		flush();
		wait_drained();

		set_limits(TOPC_W'(MAX_K), 1'b0, KCNT_W'(2));
		offer(4, 2);
		offer(4, -2);
		offer(-4, 0);
		wait_drained();
		write_reg(CFG_TOP_COUNT, CFG_DATA_W'(1));
		flush();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			if (phase == BIG_PHASE)
				set_limits(TOPC_W'(MAX_K), 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)));
			else if ($urandom_range(0, 4) != 0)
				set_limits(pick_limit(), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
			gaps_on = ($urandom_range(0, 3) != 0);
			spread = key_spread_t'($urandom_range(0, 2));
			if (phase == HOLD_PHASE) begin
				// receiver holds off while flushes pile up behind each other
				hold_req = ~hold_req;
				repeat (3) begin
					repeat ($urandom_range(2, 5)) offer(pick_key(spread), pick_key(spread));
					flush();
				end
			end else begin
				n = (phase == BIG_PHASE) ? MAX_K + 4 : $urandom_range(0, 10);
				repeat (n) begin
					if ($urandom_range(0, 9) == 0)
						flush();
					else
						offer(pick_key(spread), pick_key(spread));
				end
				if ($urandom_range(0, 5) != 0) flush();
			end
			phase++;
		end
		flush();
		wait_drained();

		$display("sent %0d items with %0d flushes over %0d phases", items_sent, flushes_sent,
			phase);
		$display("checked %0d emitted rows in %0d cycles", results_seen, cycles);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
